// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the vertex cluster quantizer.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define VCQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define VCQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/vcq_pkg.sv =====
// Package of the vertex cluster quantizer: state type, status codes, constants.
// Used by vertex_cluster_quantizer and its testbench; depends on nothing.
`timescale 1ns / 1ps
package vcq_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_REM,
        ST_OFF,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_RANGE = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    localparam logic [36:0] MASTER_BIAS = 37'd49152000;
    localparam logic [36:0] BIASED_LIMIT = 37'd10737254400;
    localparam logic [19:0] RECIP_FIVE = 20'd838861;

endpackage

// ===== rtl/vertex_cluster_quantizer.sv =====
// Top level of the vertex cluster quantizer: axis quantization and cluster table search.
// Depends on vcq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// vertex    in         i_valid / o_stall    i_pos_x/y/z, i_tex_s/t, i_color_in, i_first_vertex
// result    out        o_valid / i_stall    o_off_*, o_cluster_index, o_origin_*, o_status, ...
// A beat passes through CELL, REM, OFF, SEARCH and FINISH; the search scans stored clusters up
// to the match, a miss scans every one, and a position out of range skips from CELL to FINISH.
// The scan reads the key memory through its single read port, one entry each cycle.
// Reset clears the cluster count and the handshake state; the key memory is not cleared.
// A finished result waits in the output register while the next vertex is taken.
`include "assert_macros.svh"
module vertex_cluster_quantizer
    import vcq_pkg::*;
#(
    parameter int CLUSTER_CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [35:0] i_pos_x,
    input  logic signed [35:0] i_pos_y,
    input  logic signed [35:0] i_pos_z,
    input  logic [15:0]        i_tex_s,
    input  logic [15:0]        i_tex_t,
    input  logic [15:0]        i_color_in,
    input  logic               i_first_vertex,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_off_x,
    output logic [15:0]        o_off_y,
    output logic [15:0]        o_off_z,
    output logic [9:0]         o_cluster_index,
    output logic [15:0]        o_tex_s_out,
    output logic [15:0]        o_tex_t_out,
    output logic [15:0]        o_color_out,
    output logic               o_new_cluster,
    output logic [15:0]        o_origin_x,
    output logic [15:0]        o_origin_y,
    output logic [15:0]        o_origin_z,
    output logic [1:0]         o_status
);

    localparam int IW = (CLUSTER_CAPACITY > 1) ? $clog2(CLUSTER_CAPACITY) : 1;
    localparam int CW = $clog2(CLUSTER_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CLUSTER_CAPACITY);

    t_state r_state, n_state;

    logic [35:0] r_pos [3];
    logic [33:0] r_biased [3];
    logic [15:0] r_cell [3];
    logic [18:0] r_scaled [3];
    logic [15:0] r_off [3];
    logic        r_bad;
    logic [15:0] r_tex_s, r_tex_t, r_color;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic          r_pend;
    logic [IW-1:0] r_pend_idx;
    logic [47:0]   r_rd_data;
    logic [47:0]   mem_keys [CLUSTER_CAPACITY];

    logic        r_ov;
    logic [15:0] r_o_off [3];
    logic [15:0] r_o_origin [3];
    logic [9:0]  r_o_idx;
    logic        r_o_new;
    t_status     r_o_status;
    logic [15:0] r_o_tex_s, r_o_tex_t, r_o_color;

    logic [IW-1:0] r_res_idx;
    logic          r_res_new;
    t_status       r_res_status;

    logic          accept;
    logic          out_free;
    logic [47:0]   key;
    logic          issue;
    logic          hit;
    logic          miss;
    logic          do_write;
    logic [36:0]   biased [3];
    logic [3:0]    bad_axis;
    logic [38:0]   cell_prod [3];
    logic [33:0]   rem_full [3];
    logic [33:0]   scale_t [3];
    logic [38:0]   off_prod [3];

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;
    assign key      = {r_cell[2], r_cell[1], r_cell[0]};
    assign issue    = (r_state == ST_SEARCH) && (r_ptr < r_count);
    assign hit      = (r_state == ST_SEARCH) && r_pend && (r_rd_data == key);
    assign miss     = (r_state == ST_SEARCH) && !r_pend && !issue;
    assign do_write = miss && (r_count < CAP);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            biased[a]    = $signed({r_pos[a][35], r_pos[a]}) + $signed(MASTER_BIAS);
            bad_axis[a]  = biased[a][36] || (biased[a] >= BIASED_LIMIT);
            cell_prod[a] = {20'd0, biased[a][33:15]} * {19'd0, RECIP_FIVE};
            rem_full[a]  = r_biased[a] - (34'({r_cell[a], 17'd0}) + 34'({r_cell[a], 15'd0}));
            scale_t[a]   = {rem_full[a][17:0], 16'd0} - {16'd0, rem_full[a][17:0]};
            off_prod[a]  = {20'd0, r_scaled[a]} * {19'd0, RECIP_FIVE};
        end
        bad_axis[3] = bad_axis[0] || bad_axis[1] || bad_axis[2];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_CELL;
            ST_CELL:   n_state = bad_axis[3] ? ST_FINISH : ST_REM;
            ST_REM:    n_state = ST_OFF;
            ST_OFF:    n_state = ST_SEARCH;
            ST_SEARCH: if (hit || miss) n_state = ST_FINISH;
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_first_vertex) r_count <= '0;
            else if (do_write) r_count <= r_count + 1'b1;
            if (r_state == ST_FINISH && out_free) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
            r_pend <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_tex_s  <= i_tex_s;
            r_tex_t  <= i_tex_t;
            r_color  <= i_color_in;
        end
        if (r_state == ST_CELL) begin
            r_bad        <= bad_axis[3];
            r_res_status <= bad_axis[3] ? STATUS_RANGE : STATUS_OK;
            r_res_new    <= 1'b0;
            r_res_idx    <= '0;
        end
        for (int a = 0; a < 3; a++) begin
            if (r_state == ST_CELL) begin
                r_biased[a] <= biased[a][33:0];
                r_cell[a]   <= cell_prod[a][37:22];
            end
            if (r_state == ST_REM) r_scaled[a] <= scale_t[a][33:15];
            if (r_state == ST_OFF) r_off[a] <= off_prod[a][37:22];
        end
        if (r_state == ST_OFF) r_ptr <= '0;
        else if (issue) r_ptr <= r_ptr + 1'b1;
        if (issue) r_pend_idx <= r_ptr[IW-1:0];
        if (hit) r_res_idx <= r_pend_idx;
        if (miss) begin
            if (do_write) begin
                r_res_idx <= r_count[IW-1:0];
                r_res_new <= 1'b1;
            end else begin
                r_res_status <= STATUS_FULL;
            end
        end
        if (r_state == ST_FINISH && out_free) begin
            for (int a = 0; a < 3; a++) begin
                r_o_off[a]    <= (r_res_status == STATUS_OK) ? r_off[a] : 16'd0;
                r_o_origin[a] <= (r_res_status == STATUS_OK) ? r_cell[a] : 16'd0;
            end
            r_o_idx    <= (r_res_status == STATUS_OK) ? 10'(r_res_idx) : 10'd0;
            r_o_new    <= r_res_new && !r_bad;
            r_o_status <= r_res_status;
            r_o_tex_s  <= r_tex_s;
            r_o_tex_t  <= r_tex_t;
            r_o_color  <= r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) mem_keys[r_count[IW-1:0]] <= key;
        r_rd_data <= mem_keys[r_ptr[IW-1:0]];
    end

    assign o_valid         = r_ov;
    assign o_off_x         = r_o_off[0];
    assign o_off_y         = r_o_off[1];
    assign o_off_z         = r_o_off[2];
    assign o_origin_x      = r_o_origin[0];
    assign o_origin_y      = r_o_origin[1];
    assign o_origin_z      = r_o_origin[2];
    assign o_cluster_index = r_o_idx;
    assign o_new_cluster   = r_o_new;
    assign o_status        = r_o_status;
    assign o_tex_s_out     = r_o_tex_s;
    assign o_tex_t_out     = r_o_tex_t;
    assign o_color_out     = r_o_color;

    `VCQ_ASSERT(a_count_bound, r_count <= CAP, "cluster count exceeds capacity")
    `VCQ_ASSERT(a_new_ok, o_valid && o_new_cluster |-> o_status == STATUS_OK,
        "new cluster reported with error status")
    `VCQ_ASSERT(a_clear, accept && i_first_vertex |=> r_count == '0,
        "first vertex did not clear the table")
    `VCQ_ASSERT(a_single_hit, !(hit && miss), "search hit and miss together")
    `VCQ_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> r_state == ST_IDLE && !o_valid,
        "reset did not return the block to idle")

endmodule

// ===== dv/vertex_cluster_quantizer_tb.sv =====
// Self-checking testbench of vertex_cluster_quantizer: a queued driver and a monitor
// compare every result beat with a predictor of the axis quantization and cluster table.
// Depends on vcq_pkg and the RTL of vertex_cluster_quantizer.
`timescale 1ns / 1ps
module vertex_cluster_quantizer_tb;
    import vcq_pkg::*;

    localparam int     TABLE_DEPTH = 1024;
    localparam longint CELL_SPAN   = 163840;
    localparam longint POS_BIAS    = 49152000;
    localparam longint CELL_LIMIT  = 65535;
    localparam int     QUIET_TAIL  = 100;

    typedef struct {
        logic signed [35:0] pos_x;
        logic signed [35:0] pos_y;
        logic signed [35:0] pos_z;
        logic [15:0]        tex_s;
        logic [15:0]        tex_t;
        logic [15:0]        color;
        logic               first;
        logic               drain_before;
    } t_vertex;

    typedef struct {
        logic [15:0] off_x;
        logic [15:0] off_y;
        logic [15:0] off_z;
        logic [9:0]  index;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
        logic [15:0] color;
        logic        created;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] origin_z;
        t_status     status;
    } t_quant;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [35:0] i_pos_x;
    logic signed [35:0] i_pos_y;
    logic signed [35:0] i_pos_z;
    logic [15:0]        i_tex_s;
    logic [15:0]        i_tex_t;
    logic [15:0]        i_color_in;
    logic               i_first_vertex;
    logic               o_valid;
    logic               i_stall;
    logic [15:0]        o_off_x;
    logic [15:0]        o_off_y;
    logic [15:0]        o_off_z;
    logic [9:0]         o_cluster_index;
    logic [15:0]        o_tex_s_out;
    logic [15:0]        o_tex_t_out;
    logic [15:0]        o_color_out;
    logic               o_new_cluster;
    logic [15:0]        o_origin_x;
    logic [15:0]        o_origin_y;
    logic [15:0]        o_origin_z;
    logic [1:0]         o_status;

    t_vertex     vertex_queue[$];
    t_quant      expected_quants[$];
    logic [47:0] cluster_keys[TABLE_DEPTH];
    int          cluster_count;
    int          error_count;
    int          vertices_sent;
    int          quants_seen;
    int          vertex_total;
    int          send_gap;
    int          stall_burst;
    int          long_hold;
    bit          long_hold_done;

    vertex_cluster_quantizer DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic quantize(input logic signed [35:0] pos, output logic [15:0] cell_no,
                                      output logic [15:0] off);
        longint biased;
        longint c;
        cell_no = '0;
        off     = '0;
        biased = longint'(pos) + POS_BIAS;
        if (biased < 0) return 1'b0;
        c = biased / CELL_SPAN;
        if (c >= CELL_LIMIT) return 1'b0;
        cell_no = c[15:0];
        off     = 16'(((biased - c * CELL_SPAN) * 65535) / CELL_SPAN);
        return 1'b1;
    endfunction

    function automatic t_quant predict_quant(input t_vertex v);
        t_quant      q;
        logic        ok;
        logic        found;
        logic [47:0] key;
        q = '{default: '0};
        q.tex_s = v.tex_s;
        q.tex_t = v.tex_t;
        q.color = v.color;
        q.status = STATUS_OK;
        found = 1'b0;
        if (v.first) cluster_count = 0;
        ok = quantize(v.pos_x, q.origin_x, q.off_x);
        ok = quantize(v.pos_y, q.origin_y, q.off_y) & ok;
        ok = quantize(v.pos_z, q.origin_z, q.off_z) & ok;
        if (!ok) begin
            q.status = STATUS_RANGE;
        end else begin
            key = {q.origin_z, q.origin_y, q.origin_x};
            for (int i = 0; i < cluster_count; i++) begin
                if (!found && cluster_keys[i] == key) begin
                    found = 1'b1;
                    q.index = 10'(i);
                end
            end
            if (!found) begin
                if (cluster_count >= TABLE_DEPTH) begin
                    q.status = STATUS_FULL;
                end else begin
                    cluster_keys[cluster_count] = key;
                    q.index = 10'(cluster_count);
                    q.created = 1'b1;
                    cluster_count++;
                end
            end
        end
        if (q.status != STATUS_OK) begin
            q.off_x = '0; q.off_y = '0; q.off_z = '0; q.index = '0; q.created = 1'b0;
            q.origin_x = '0; q.origin_y = '0; q.origin_z = '0;
        end
        return q;
    endfunction

    function automatic logic signed [35:0] place(input longint cell_no, input longint rem);
        return 36'(cell_no * CELL_SPAN + rem - POS_BIAS);
    endfunction

    function automatic logic signed [35:0] random_raw();
        return 36'({$urandom(), $urandom()});
    endfunction

    task automatic add_vertex(input logic signed [35:0] px, input logic signed [35:0] py,
                              input logic signed [35:0] pz, input logic first,
                              input logic drain_before = 1'b0);
        t_vertex v;
        v.pos_x = px; v.pos_y = py; v.pos_z = pz;
        v.tex_s = 16'($urandom()); v.tex_t = 16'($urandom()); v.color = 16'($urandom());
        v.first = first;
        v.drain_before = drain_before;
        vertex_queue.insert(vertex_queue.size(), v);
    endtask

    // A set mostly opens with a table clear and draws cells from a small pool so lookups hit.
    task automatic add_cluster_set();
        longint pool_x[4];
        longint pool_y[4];
        longint pool_z[4];
        int     n;
        foreach (pool_x[k]) begin
            pool_x[k] = $urandom_range(0, 65534);
            pool_y[k] = $urandom_range(0, 65534);
            pool_z[k] = $urandom_range(0, 65534);
        end
        n = $urandom_range(1, 30);
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_vertex($urandom_range(0, 1) ? random_raw() : place(pool_x[0], -1),
                           random_raw(), place(pool_z[1], 5), $urandom_range(0, 7) == 0);
            end else begin
                add_vertex(place(pool_x[$urandom_range(0, 3)], $urandom_range(0, 163839)),
                           place(pool_y[$urandom_range(0, 3)], $urandom_range(0, 163839)),
                           place(pool_z[$urandom_range(0, 3)], $urandom_range(0, 163839)),
                           j == 0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex v;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_quants.insert(expected_quants.size(),
                    predict_quant('{i_pos_x, i_pos_y, i_pos_z, i_tex_s, i_tex_t, i_color_in,
                                    i_first_vertex, 1'b0}));
                vertices_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (vertex_queue.size() == 0 ||
                             (vertex_queue[0].drain_before && expected_quants.size() != 0)) begin
                    i_valid <= 1'b0;
                end else if (vertices_sent < vertex_total - QUIET_TAIL &&
                             $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 13);
                    i_valid <= 1'b0;
                end else begin
                    v = vertex_queue.pop_front();
                    i_pos_x        <= v.pos_x;
                    i_pos_y        <= v.pos_y;
                    i_pos_z        <= v.pos_z;
                    i_tex_s        <= v.tex_s;
                    i_tex_t        <= v.tex_t;
                    i_color_in     <= v.color;
                    i_first_vertex <= v.first;
                    i_valid        <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_quant q;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                quants_seen++;
                if (expected_quants.size() == 0) begin
                    $error("Result beat arrived with no vertex outstanding");
                    error_count++;
                end else begin
                    q = expected_quants.pop_front();
                    check_field("off_x", 64'(q.off_x), 64'(o_off_x));
                    check_field("off_y", 64'(q.off_y), 64'(o_off_y));
                    check_field("off_z", 64'(q.off_z), 64'(o_off_z));
                    check_field("cluster_index", 64'(q.index), 64'(o_cluster_index));
                    check_field("tex_s_out", 64'(q.tex_s), 64'(o_tex_s_out));
                    check_field("tex_t_out", 64'(q.tex_t), 64'(o_tex_t_out));
                    check_field("color_out", 64'(q.color), 64'(o_color_out));
                    check_field("new_cluster", 64'(q.created), 64'(o_new_cluster));
                    check_field("origin_x", 64'(q.origin_x), 64'(o_origin_x));
                    check_field("origin_y", 64'(q.origin_y), 64'(o_origin_y));
                    check_field("origin_z", 64'(q.origin_z), 64'(o_origin_z));
                    check_field("status", 64'(q.status), 64'(o_status));
                end
            end
            if (!long_hold_done && quants_seen >= 300) begin
                long_hold_done = 1'b1;
                long_hold = 400;
                i_stall <= 1'b1;
            end else if (long_hold > 0) begin
                long_hold--;
                i_stall <= 1'b1;
            end else if (stall_burst > 0) begin
                stall_burst--;
                i_stall <= 1'b1;
            end else if (quants_seen < vertex_total - QUIET_TAIL &&
                         $urandom_range(0, 11) == 0) begin
                stall_burst = $urandom_range(0, 13);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_tex_s = '0; i_tex_t = '0; i_color_in = '0;
        i_first_vertex = 1'b0;
        error_count = 0; vertices_sent = 0; quants_seen = 0; cluster_count = 0;
        send_gap = 0; stall_burst = 0; long_hold = 0; long_hold_done = 1'b0;
        vertex_total = 1 << 30;

        // Directed: range edges of each axis, pass-through extremes, hits and a clear.
        add_vertex(place(0, 0), place(0, 0), place(0, 0), 1'b1);
        add_vertex(place(65534, 163839), place(65534, 163839), place(65534, 163839), 1'b0);
        add_vertex(place(0, 0), place(0, 0), place(0, 0), 1'b0);
        add_vertex(place(0, -1), place(3, 0), place(3, 0), 1'b0);
        add_vertex(place(3, 0), place(0, -1), place(3, 0), 1'b0);
        add_vertex(place(3, 0), place(3, 0), place(0, -1), 1'b0);
        add_vertex(place(65535, 0), place(3, 0), place(3, 0), 1'b0);
        add_vertex(place(3, 0), place(65535, 0), place(3, 0), 1'b0);
        add_vertex(place(3, 0), place(3, 0), place(65535, 0), 1'b0);
        add_vertex(36'sh8_0000_0000, 36'sh7_FFFF_FFFF, 36'sh0, 1'b0);
        add_vertex(36'sh7_FFFF_FFFF, 36'sh8_0000_0000, 36'shF_FFFF_FFFF, 1'b0);
        add_vertex(36'sh0, 36'sh0, 36'sh0, 1'b0);
        add_vertex(36'shF_FFFF_FFFF, 36'sh0, 36'sh1, 1'b0);
        add_vertex(place(7, 81920), place(9, 1), place(11, 163838), 1'b0);
        add_vertex(place(7, 5), place(9, 163839), place(11, 0), 1'b0);
        add_vertex(place(65534, 163839), place(65534, 163839), place(65534, 163839), 1'b1);
        add_vertex(place(7, 5), place(9, 163839), place(11, 0), 1'b0);
        vertex_queue[0].tex_s = '0; vertex_queue[0].tex_t = '0; vertex_queue[0].color = '0;
        vertex_queue[1].tex_s = '1; vertex_queue[1].tex_t = '1; vertex_queue[1].color = '1;

        while (vertex_queue.size() < 450) add_cluster_set();

        // Fill the table past its capacity, then mix revisits with keys that no longer fit.
        for (int k = 0; k < TABLE_DEPTH + 6; k++) begin
            add_vertex(place(k, $urandom_range(0, 163839)), place(42, 7),
                       place(65534 - (k % 5), 9), k == 0, k == 0);
        end
        for (int k = 0; k < 24; k++) begin
            add_vertex(place($urandom_range(0, TABLE_DEPTH + 100), 3), place(42, 7),
                       place(65534 - (k % 5), 9), 1'b0);
        end

        add_cluster_set();
        vertex_queue[vertex_queue.size() - 1].drain_before = 1'b1;
        while (vertex_queue.size() < 1950) add_cluster_set();
        vertex_total = vertex_queue.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (vertex_queue.size() != 0 || expected_quants.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (TABLE_DEPTH + 20) @(posedge i_clk);
        if (error_count == 0 && expected_quants.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vcq_pkg.sv
rtl/vertex_cluster_quantizer.sv
dv/vertex_cluster_quantizer_tb.sv
